/* src/dpmq_pkg.sv */
// ----------------------------------------------------------------------------
// Deferred protection merge queue package
// Shared codes, sequencer states and the compare unit's result word.
// ----------------------------------------------------------------------------
package dpmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 48;

  // Fixed field widths.
  localparam int START_W = 48;
  localparam int LEN_W   = 33;
  localparam int CLEN_W  = 49;
  localparam int PROT_W  = 3;
  localparam int TAG_W   = 64;
  localparam int OP_W    = 3;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BYPASS    = 1'd0,
    REG_BASE_ADDR = 1'd1
  } reg_e;

  typedef enum logic [OP_W-1:0] {
    OP_PROTECT     = 3'd0,
    OP_PROTECT_NOW = 3'd1,
    OP_FLUSH_ALL   = 3'd2,
    OP_FLUSH_RANGE = 3'd3,
    OP_FLUSH_GUEST = 3'd4,
    OP_FLUSH_TAG   = 3'd5
  } op_e;

  localparam logic [PROT_W-1:0] PROT_RW = 3'd0;
  localparam logic [PROT_W-1:0] PROT_RO = 3'd1;
  localparam logic [PROT_W-1:0] PROT_NO = 3'd2;
  localparam logic [PROT_W-1:0] PROT_WX = 3'd3;
  localparam logic [PROT_W-1:0] PROT_RX = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_COMPACT,
    ST_SELF,
    ST_APPEND
  } state_e;

  typedef enum logic [2:0] {
    MD_UNLOCK,
    MD_DEFER,
    MD_IMM,
    MD_RANGE,
    MD_TAG,
    MD_ALL
  } mode_e;

  // Relation of one queued entry to the request.
  typedef struct packed {
    logic overlap;   // ranges share an address
    logic touch;     // ranges overlap or abut
    logic covered;   // entry lies wholly inside the request
    logic start_lt;  // request start below entry start
    logic end_gt;    // request end above entry end
    logic tag_gt;    // entry tag above the request tag
  } cmp_t;

endpackage

/* src/dpmq_cmp.sv */
// ----------------------------------------------------------------------------
// Entry compare unit
// Relates the entry under the scan pointer to the request range and tag.
// ----------------------------------------------------------------------------
module dpmq_cmp #(
  parameter int ADDR_BITS = dpmq_pkg::ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0]        ent_start_i,
  input  logic [ADDR_BITS-1:0]        ent_end_i,
  input  logic [dpmq_pkg::TAG_W-1:0]  ent_tag_i,
  input  logic [ADDR_BITS-1:0]        req_start_i,
  input  logic [ADDR_BITS-1:0]        req_end_i,
  input  logic [dpmq_pkg::TAG_W-1:0]  req_tag_i,
  output dpmq_pkg::cmp_t              cmp_o
);

  logic [ADDR_BITS:0] ent_end_inc;
  logic [ADDR_BITS:0] req_end_inc;

  // One past the end; at the top of the space this never equals a start.
  assign ent_end_inc = {1'b0, ent_end_i} + (ADDR_BITS+1)'(1);
  assign req_end_inc = {1'b0, req_end_i} + (ADDR_BITS+1)'(1);

  always_comb begin
    cmp_o.overlap  = (ent_start_i <= req_end_i) && (req_start_i <= ent_end_i);
    cmp_o.touch    = cmp_o.overlap
                   || (ent_end_inc == {1'b0, req_start_i})
                   || (req_end_inc == {1'b0, ent_start_i});
    cmp_o.covered  = (req_start_i <= ent_start_i) && (ent_end_i <= req_end_i);
    cmp_o.start_lt = req_start_i < ent_start_i;
    cmp_o.end_gt   = req_end_i > ent_end_i;
    cmp_o.tag_gt   = ent_tag_i > req_tag_i;
  end

endmodule

/* src/deferred_protection_merge_queue_core.sv */
// ----------------------------------------------------------------------------
// Deferred protection merge queue core
// Ordered queue of pending protection changes with merge, unlock and flush.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o  | operation, range, protection, tag
//  out     | output    | out_valid_o/out_ready_i| cmd_start, cmd_length, cmd_protection, last
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// A request is accepted, then scanned from newest to oldest entry through one
// compare unit; the words are issued, a compaction pass runs over a single entry
// read port, and a last step handles the request itself.
// A full queue with a new entry runs a second issue and compaction pass.
// Reset empties the queue. A stalled output holds the sequencer in place.
module deferred_protection_merge_queue_core #(
  parameter int QUEUE_DEPTH = dpmq_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = dpmq_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpmq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dpmq_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dpmq_pkg::OP_W-1:0]     operation_i,
  input  logic [dpmq_pkg::START_W-1:0]  range_start_i,
  input  logic [dpmq_pkg::LEN_W-1:0]    range_length_i,
  input  logic [dpmq_pkg::PROT_W-1:0]   protection_i,
  input  logic [dpmq_pkg::TAG_W-1:0]    tag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dpmq_pkg::START_W-1:0]  cmd_start_o,
  output logic [dpmq_pkg::CLEN_W-1:0]   cmd_length_o,
  output logic [dpmq_pkg::PROT_W-1:0]   cmd_protection_o,
  output logic                          last_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int AW    = ADDR_BITS;

  typedef logic [AW-1:0] addr_t;

  // Entry store.
  addr_t                             ent_start_q [QUEUE_DEPTH];
  addr_t                             ent_end_q   [QUEUE_DEPTH];
  logic [dpmq_pkg::PROT_W-1:0]       ent_prot_q  [QUEUE_DEPTH];
  logic [dpmq_pkg::TAG_W-1:0]        ent_tag_q   [QUEUE_DEPTH];

  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_idx;
  addr_t                             wr_start, wr_end;
  logic [dpmq_pkg::PROT_W-1:0]       wr_prot;
  logic [dpmq_pkg::TAG_W-1:0]        wr_tag;
  logic [IDX_W-1:0]                  rd_idx;
  addr_t                             rd_start, rd_end;
  logic [dpmq_pkg::PROT_W-1:0]       rd_prot;
  logic [dpmq_pkg::TAG_W-1:0]        rd_tag;

  // Sequencer state.
  dpmq_pkg::state_e                  state_q, state_d;
  dpmq_pkg::mode_e                   mode_q, mode_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [CNT_W-1:0]                  scan_q, scan_d;
  logic [CNT_W-1:0]                  k_q, k_d;
  logic [CNT_W-1:0]                  rm_q, rm_d;
  logic [CNT_W-1:0]                  em_q, em_d;
  logic [CNT_W-1:0]                  src_q, src_d;
  logic [CNT_W-1:0]                  dst_q, dst_d;
  logic [QUEUE_DEPTH-1:0]            drop_q, drop_d;
  logic                              found_q, found_d;
  logic                              merged_q, merged_d;
  logic                              second_q, second_d;
  logic                              self_q, self_d;

  addr_t                             req_s_q, req_s_d;
  addr_t                             req_e_q, req_e_d;
  logic [dpmq_pkg::PROT_W-1:0]       req_p_q, req_p_d;
  logic [dpmq_pkg::TAG_W-1:0]        req_tag_q, req_tag_d;

  logic                              bypass_q;
  logic [dpmq_pkg::CFG_W-1:0]        base_addr_q;

  // Output register.
  logic                              out_valid_q;
  logic [dpmq_pkg::START_W-1:0]      out_start_q;
  logic [dpmq_pkg::CLEN_W-1:0]       out_len_q;
  logic [dpmq_pkg::PROT_W-1:0]       out_prot_q;
  logic                              out_last_q;
  logic                              out_free;
  logic                              out_load;
  logic                              ld_self;
  logic                              ld_last;
  addr_t                             ld_s, ld_e;
  logic [dpmq_pkg::PROT_W-1:0]       ld_p;
  logic [AW:0]                       ld_len;
  logic [64:0]                       ld_len_w;
  logic [63:0]                       ld_s_w;

  // Request decode.
  logic [63:0]                       in_start_w;
  logic [63:0]                       gbase_w;
  addr_t                             in_s, in_e, in_guest;
  logic [AW:0]                       in_sum;
  logic                              in_zero;

  dpmq_pkg::cmp_t                    cmp;
  logic [IDX_W-1:0]                  scan_x;
  logic                              keep;

  assign in_start_w = 64'(range_start_i);
  assign gbase_w    = 64'(base_addr_q);
  assign in_s       = in_start_w[AW-1:0];
  assign in_guest   = gbase_w[AW-1:0] + in_s;
  assign in_sum     = {1'b0, in_s} + (AW+1)'(range_length_i) - (AW+1)'(1);
  assign in_e       = in_sum[AW] ? '1 : in_sum[AW-1:0];
  assign in_zero    = (range_length_i == '0);

  assign scan_x = IDX_W'(scan_q - CNT_W'(1));

  always_comb begin
    case (state_q)
      dpmq_pkg::ST_SCAN:    rd_idx = scan_x;
      dpmq_pkg::ST_EMIT:    rd_idx = em_q[IDX_W-1:0];
      dpmq_pkg::ST_COMPACT: rd_idx = src_q[IDX_W-1:0];
      default:              rd_idx = '0;
    endcase
  end

  assign rd_start = ent_start_q[rd_idx];
  assign rd_end   = ent_end_q[rd_idx];
  assign rd_prot  = ent_prot_q[rd_idx];
  assign rd_tag   = ent_tag_q[rd_idx];

  dpmq_cmp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_cmp (
    .ent_start_i (rd_start),
    .ent_end_i   (rd_end),
    .ent_tag_i   (rd_tag),
    .req_start_i (req_s_q),
    .req_end_i   (req_e_q),
    .req_tag_i   (req_tag_q),
    .cmp_o       (cmp)
  );

  assign keep     = !((src_q < rm_q) || drop_q[src_q[IDX_W-1:0]]);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    k_d       = k_q;
    rm_d      = rm_q;
    em_d      = em_q;
    src_d     = src_q;
    dst_d     = dst_q;
    drop_d    = drop_q;
    found_d   = found_q;
    merged_d  = merged_q;
    second_d  = second_q;
    self_d    = self_q;
    req_s_d   = req_s_q;
    req_e_d   = req_e_q;
    req_p_d   = req_p_q;
    req_tag_d = req_tag_q;
    wr_en     = 1'b0;
    wr_idx    = rd_idx;
    wr_start  = rd_start;
    wr_end    = rd_end;
    wr_prot   = rd_prot;
    wr_tag    = rd_tag;
    out_load  = 1'b0;
    ld_self   = 1'b0;
    ld_last   = 1'b0;

    case (state_q)
      dpmq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_s_d   = in_s;
          req_e_d   = in_e;
          req_p_d   = protection_i;
          req_tag_d = tag_i;
          scan_d    = cnt_q;
          k_d       = '0;
          rm_d      = '0;
          em_d      = '0;
          drop_d    = '0;
          found_d   = 1'b0;
          merged_d  = 1'b0;
          second_d  = 1'b0;
          self_d    = 1'b0;
          state_d   = dpmq_pkg::ST_SCAN;
          case (operation_i)
            dpmq_pkg::OP_PROTECT: begin
              if (in_zero) begin
                state_d = dpmq_pkg::ST_IDLE;
              end else if (bypass_q) begin
                state_d = dpmq_pkg::ST_SELF;
              end else if (protection_i == dpmq_pkg::PROT_RW ||
                           protection_i == dpmq_pkg::PROT_WX) begin
                mode_d = dpmq_pkg::MD_UNLOCK;
                self_d = 1'b1;
              end else begin
                mode_d = dpmq_pkg::MD_DEFER;
              end
            end
            dpmq_pkg::OP_PROTECT_NOW: begin
              mode_d = dpmq_pkg::MD_IMM;
              self_d = 1'b1;
              if (in_zero) state_d = dpmq_pkg::ST_IDLE;
            end
            dpmq_pkg::OP_FLUSH_ALL: begin
              mode_d  = dpmq_pkg::MD_ALL;
              k_d     = cnt_q;
              rm_d    = cnt_q;
              state_d = dpmq_pkg::ST_EMIT;
            end
            dpmq_pkg::OP_FLUSH_RANGE: begin
              mode_d = dpmq_pkg::MD_RANGE;
              if (in_zero) state_d = dpmq_pkg::ST_IDLE;
            end
            dpmq_pkg::OP_FLUSH_GUEST: begin
              mode_d  = dpmq_pkg::MD_RANGE;
              req_s_d = in_guest;
              req_e_d = in_guest;
            end
            dpmq_pkg::OP_FLUSH_TAG: begin
              mode_d = dpmq_pkg::MD_TAG;
              k_d    = cnt_q;
            end
            default: state_d = dpmq_pkg::ST_IDLE;
          endcase
        end
      end

      dpmq_pkg::ST_SCAN: begin
        if (scan_q == '0) begin
          if (mode_q != dpmq_pkg::MD_DEFER && mode_q != dpmq_pkg::MD_UNLOCK) begin
            rm_d = k_q;
          end
          state_d = dpmq_pkg::ST_EMIT;
        end else begin
          scan_d = scan_q - CNT_W'(1);
          case (mode_q)
            dpmq_pkg::MD_UNLOCK: begin
              if (found_q || cmp.overlap) begin
                if (!found_q) begin
                  found_d = 1'b1;
                  rm_d    = scan_q;
                end
                if (cmp.covered) begin
                  k_d = scan_q - CNT_W'(1);
                end else begin
                  k_d    = scan_q;
                  scan_d = '0;
                end
              end
            end
            dpmq_pkg::MD_DEFER: begin
              if (cmp.touch) begin
                if (rd_prot != req_p_q) begin
                  if (cmp.covered) begin
                    drop_d[scan_x] = 1'b1;
                  end else if (cmp.overlap) begin
                    scan_d = '0;
                  end
                end else begin
                  // Grow the newest matching entry to cover the request.
                  wr_en    = 1'b1;
                  wr_start = cmp.start_lt ? req_s_q : rd_start;
                  wr_end   = cmp.end_gt ? req_e_q : rd_end;
                  merged_d = 1'b1;
                  scan_d   = '0;
                end
              end
            end
            dpmq_pkg::MD_IMM: begin
              if (cmp.overlap) begin
                k_d    = cnt_q;
                scan_d = '0;
              end
            end
            dpmq_pkg::MD_RANGE: begin
              if (cmp.overlap) begin
                k_d    = scan_q;
                scan_d = '0;
              end
            end
            dpmq_pkg::MD_TAG: begin
              // The lowest entry past the limit ends the flushed prefix.
              if (cmp.tag_gt) k_d = scan_q - CNT_W'(1);
            end
            default: scan_d = '0;
          endcase
        end
      end

      dpmq_pkg::ST_EMIT: begin
        if (em_q == k_q) begin
          src_d   = '0;
          dst_d   = '0;
          state_d = dpmq_pkg::ST_COMPACT;
        end else if (out_free) begin
          out_load = 1'b1;
          ld_last  = (em_q == k_q - CNT_W'(1)) && !self_q;
          em_d     = em_q + CNT_W'(1);
        end
      end

      dpmq_pkg::ST_COMPACT: begin
        if (src_q == cnt_q) begin
          cnt_d  = dst_q;
          drop_d = '0;
          if (mode_q == dpmq_pkg::MD_DEFER) begin
            if (merged_q) begin
              state_d = dpmq_pkg::ST_IDLE;
            end else if (!second_q && dst_q == CNT_W'(QUEUE_DEPTH)) begin
              // Full queue: issue and remove the oldest word first.
              second_d = 1'b1;
              k_d      = CNT_W'(1);
              rm_d     = CNT_W'(1);
              em_d     = '0;
              state_d  = dpmq_pkg::ST_EMIT;
            end else begin
              state_d = dpmq_pkg::ST_APPEND;
            end
          end else if (self_q) begin
            state_d = dpmq_pkg::ST_SELF;
          end else begin
            state_d = dpmq_pkg::ST_IDLE;
          end
        end else begin
          if (keep) begin
            wr_en  = 1'b1;
            wr_idx = dst_q[IDX_W-1:0];
            dst_d  = dst_q + CNT_W'(1);
          end
          src_d = src_q + CNT_W'(1);
        end
      end

      dpmq_pkg::ST_SELF: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_self  = 1'b1;
          ld_last  = 1'b1;
          state_d  = dpmq_pkg::ST_IDLE;
        end
      end

      dpmq_pkg::ST_APPEND: begin
        wr_en    = 1'b1;
        wr_idx   = cnt_q[IDX_W-1:0];
        wr_start = req_s_q;
        wr_end   = req_e_q;
        wr_prot  = req_p_q;
        wr_tag   = req_tag_q;
        cnt_d    = cnt_q + CNT_W'(1);
        state_d  = dpmq_pkg::ST_IDLE;
      end

      default: state_d = dpmq_pkg::ST_IDLE;
    endcase
  end

  // Output word build.
  assign ld_s     = ld_self ? req_s_q : rd_start;
  assign ld_e     = ld_self ? req_e_q : rd_end;
  assign ld_p     = ld_self ? req_p_q : rd_prot;
  assign ld_len   = {1'b0, ld_e} - {1'b0, ld_s} + (AW+1)'(1);
  assign ld_len_w = 65'(ld_len);
  assign ld_s_w   = 64'(ld_s);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_start_q[wr_idx] <= wr_start;
      ent_end_q[wr_idx]   <= wr_end;
      ent_prot_q[wr_idx]  <= wr_prot;
      ent_tag_q[wr_idx]   <= wr_tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpmq_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      bypass_q    <= 1'b0;
      base_addr_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          dpmq_pkg::REG_BYPASS:    bypass_q    <= cfg_data_i[0];
          dpmq_pkg::REG_BASE_ADDR: base_addr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    scan_q    <= scan_d;
    k_q       <= k_d;
    rm_q      <= rm_d;
    em_q      <= em_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    drop_q    <= drop_d;
    found_q   <= found_d;
    merged_q  <= merged_d;
    second_q  <= second_d;
    self_q    <= self_d;
    req_s_q   <= req_s_d;
    req_e_q   <= req_e_d;
    req_p_q   <= req_p_d;
    req_tag_q <= req_tag_d;
    if (out_load) begin
      out_start_q <= ld_s_w[dpmq_pkg::START_W-1:0];
      out_len_q   <= ld_len_w[dpmq_pkg::CLEN_W-1:0];
      out_prot_q  <= ld_p;
      out_last_q  <= ld_last;
    end
  end

  assign in_ready_o       = (state_q == dpmq_pkg::ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign cmd_start_o      = out_start_q;
  assign cmd_length_o     = out_len_q;
  assign cmd_protection_o = out_prot_q;
  assign last_o           = out_last_q;

endmodule

/* tb/sv/dpmq_checker.sv */
// ----------------------------------------------------------------------------
// Deferred protection merge queue checker
// Watches the request, command and register ports, keeps its own copy of the
// pending-change queue, predicts every issued command and compares each one
// as it leaves the core.
// ----------------------------------------------------------------------------
module dpmq_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dpmq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dpmq_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [dpmq_pkg::OP_W-1:0]      operation_i,
  input  logic [dpmq_pkg::START_W-1:0]   range_start_i,
  input  logic [dpmq_pkg::LEN_W-1:0]     range_length_i,
  input  logic [dpmq_pkg::PROT_W-1:0]    protection_i,
  input  logic [dpmq_pkg::TAG_W-1:0]     tag_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [dpmq_pkg::START_W-1:0]   cmd_start_i,
  input  logic [dpmq_pkg::CLEN_W-1:0]    cmd_length_i,
  input  logic [dpmq_pkg::PROT_W-1:0]    cmd_protection_i,
  input  logic                           last_i,
  output int                             errors_o,
  output int                             pending_o
);

  localparam int DEPTH = dpmq_pkg::QUEUE_DEPTH_DEF;
  localparam logic [dpmq_pkg::START_W-1:0] ADDR_MAX = '1;

  typedef logic [dpmq_pkg::START_W-1:0] addr_t;

  typedef struct packed {
    logic [dpmq_pkg::START_W-1:0] start;
    logic [dpmq_pkg::CLEN_W-1:0]  len;
    logic [dpmq_pkg::PROT_W-1:0]  prot;
    logic                         last;
  } cmd_t;

  addr_t                        pend_lo[DEPTH];
  addr_t                        pend_hi[DEPTH];
  logic [dpmq_pkg::PROT_W-1:0]  pend_prot[DEPTH];
  logic [dpmq_pkg::TAG_W-1:0]   pend_tag[DEPTH];
  int                           pend_n = 0;
  logic                         bypass = 1'b0;
  logic [dpmq_pkg::CFG_W-1:0]   base_addr = '0;
  cmd_t                         cmd_q[$];
  int                           errors = 0;

  assign errors_o  = errors;
  assign pending_o = cmd_q.size();

  function automatic bit hit(addr_t as, addr_t ae, addr_t bs, addr_t be);
    return as <= be && bs <= ae;
  endfunction

  function automatic bit abuts(addr_t as, addr_t ae, addr_t bs, addr_t be);
    return hit(as, ae, bs, be) || (ae != ADDR_MAX && ae + 1'b1 == bs) ||
           (be != ADDR_MAX && be + 1'b1 == as);
  endfunction

  function automatic void issue(addr_t s, addr_t e, logic [dpmq_pkg::PROT_W-1:0] p);
    cmd_t c;
    c.start = s;
    c.len   = {1'b0, e} - {1'b0, s} + 1'b1;
    c.prot  = p;
    c.last  = 1'b0;
    cmd_q.insert(cmd_q.size(), c);
  endfunction

  function automatic void drop_entry(int i);
    for (int j = i; j + 1 < pend_n; j++) begin
      pend_lo[j]   = pend_lo[j+1];
      pend_hi[j]   = pend_hi[j+1];
      pend_prot[j] = pend_prot[j+1];
      pend_tag[j]  = pend_tag[j+1];
    end
    pend_n--;
  endfunction

  function automatic void flush_front(int k);
    int cnt;
    cnt = (k > pend_n) ? pend_n : k;
    for (int i = 0; i < cnt; i++) issue(pend_lo[i], pend_hi[i], pend_prot[i]);
    for (int i = 0; i < cnt; i++) drop_entry(0);
  endfunction

  // Number of entries up to and including the newest one overlapping [s, e].
  function automatic int newest_hit(addr_t s, addr_t e);
    for (int i = pend_n; i > 0; i--)
      if (hit(pend_lo[i-1], pend_hi[i-1], s, e)) return i;
    return 0;
  endfunction

  function automatic void unlock(addr_t s, addr_t e, logic [dpmq_pkg::PROT_W-1:0] p);
    int top;
    int k;
    top = newest_hit(s, e);
    k = top;
    // Newest entries wholly covered by the unlock are superseded, not issued.
    while (k > 0 && s <= pend_lo[k-1] && pend_hi[k-1] <= e) k--;
    flush_front(k);
    for (int i = k; i < top; i++) drop_entry(k);
    issue(s, e, p);
  endfunction

  function automatic void defer(addr_t s, addr_t e, logic [dpmq_pkg::PROT_W-1:0] p,
                                logic [dpmq_pkg::TAG_W-1:0] tg);
    bit drop[DEPTH];
    bit merged;
    int x;
    merged = 1'b0;
    for (int i = 0; i < DEPTH; i++) drop[i] = 1'b0;
    for (int i = pend_n; i > 0; i--) begin
      x = i - 1;
      if (!abuts(pend_lo[x], pend_hi[x], s, e)) continue;
      if (pend_prot[x] != p) begin
        if (s <= pend_lo[x] && pend_hi[x] <= e) begin
          drop[x] = 1'b1;
          continue;
        end
        if (!hit(pend_lo[x], pend_hi[x], s, e)) continue;
        break;
      end
      if (s < pend_lo[x]) pend_lo[x] = s;
      if (e > pend_hi[x]) pend_hi[x] = e;
      merged = 1'b1;
      break;
    end
    for (int i = pend_n; i > 0; i--) if (drop[i-1]) drop_entry(i - 1);
    if (merged) return;
    if (pend_n >= DEPTH) flush_front(1);
    pend_lo[pend_n]   = s;
    pend_hi[pend_n]   = e;
    pend_prot[pend_n] = p;
    pend_tag[pend_n]  = tg;
    pend_n++;
  endfunction

  function automatic void predict(logic [dpmq_pkg::OP_W-1:0] op, addr_t s,
                                  logic [dpmq_pkg::LEN_W-1:0] len,
                                  logic [dpmq_pkg::PROT_W-1:0] p,
                                  logic [dpmq_pkg::TAG_W-1:0] tg);
    int prior;
    int k;
    logic [63:0] wide_end;
    addr_t e;
    addr_t a;
    prior = cmd_q.size();
    e = '0;
    if (len != 0) begin
      wide_end = {16'b0, s} + {31'b0, len} - 64'd1;
      e = (wide_end > {16'b0, ADDR_MAX}) ? ADDR_MAX : wide_end[dpmq_pkg::START_W-1:0];
    end
    case (op)
      dpmq_pkg::OP_PROTECT: begin
        if (len != 0) begin
          if (bypass) issue(s, e, p);
          else if (p == dpmq_pkg::PROT_RW || p == dpmq_pkg::PROT_WX) unlock(s, e, p);
          else defer(s, e, p, tg);
        end
      end
      dpmq_pkg::OP_PROTECT_NOW: begin
        if (len != 0) begin
          if (newest_hit(s, e) > 0) flush_front(pend_n);
          issue(s, e, p);
        end
      end
      dpmq_pkg::OP_FLUSH_ALL: flush_front(pend_n);
      dpmq_pkg::OP_FLUSH_RANGE: if (len != 0) flush_front(newest_hit(s, e));
      dpmq_pkg::OP_FLUSH_GUEST: begin
        a = base_addr + s;
        flush_front(newest_hit(a, a));
      end
      dpmq_pkg::OP_FLUSH_TAG: begin
        k = 0;
        while (k < pend_n && pend_tag[k] <= tg) k++;
        flush_front(k);
      end
      default: ;
    endcase
    if (cmd_q.size() > prior) cmd_q[cmd_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    cmd_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (cmd_q.size() == 0) begin
          errors++;
          $display("%0t unexpected word: start %h length %h prot %h last %b", $time,
                   cmd_start_i, cmd_length_i, cmd_protection_i, last_i);
        end else begin
          want = cmd_q.pop_front();
          if (cmd_start_i !== want.start) begin
            errors++;
            $display("%0t cmd_start: expected %h actual %h", $time, want.start,
                     cmd_start_i);
          end
          if (cmd_length_i !== want.len) begin
            errors++;
            $display("%0t cmd_length: expected %h actual %h", $time, want.len,
                     cmd_length_i);
          end
          if (cmd_protection_i !== want.prot) begin
            errors++;
            $display("%0t cmd_protection: expected %h actual %h", $time, want.prot,
                     cmd_protection_i);
          end
          if (last_i !== want.last) begin
            errors++;
            $display("%0t last: expected %b actual %b", $time, want.last, last_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == dpmq_pkg::REG_BYPASS) bypass = cfg_data_i[0];
        else if (cfg_index_i == dpmq_pkg::REG_BASE_ADDR) base_addr = cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        predict(operation_i, range_start_i, range_length_i, protection_i, tag_i);
    end
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Deferred protection merge queue testbench
// Drives directed and random protect and flush requests with random gaps and
// output stalls across several register settings; the checker compares every
// issued command against its own prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 3000;
  localparam int SW = dpmq_pkg::START_W;
  localparam int LW = dpmq_pkg::LEN_W;
  localparam int PW = dpmq_pkg::PROT_W;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [dpmq_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [dpmq_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [dpmq_pkg::OP_W-1:0]      operation_i = '0;
  logic [SW-1:0]                  range_start_i = '0;
  logic [LW-1:0]                  range_length_i = '0;
  logic [PW-1:0]                  protection_i = '0;
  logic [dpmq_pkg::TAG_W-1:0]     tag_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [SW-1:0]                  cmd_start_o;
  logic [dpmq_pkg::CLEN_W-1:0]    cmd_length_o;
  logic [PW-1:0]                  cmd_protection_o;
  logic                           last_o;

  int errors;
  int pending;
  int in_gap_max = 13;
  int out_gap_max = 13;
  int idle_cycles = 0;

  logic [SW-1:0]                  window;
  logic [dpmq_pkg::CFG_W-1:0]     base_addr;
  logic [dpmq_pkg::TAG_W-1:0]     tag_ctr = 64'd1;

  always #10 clk_i = ~clk_i;

  deferred_protection_merge_queue_core dut (.*);

  dpmq_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .range_start_i,
    .range_length_i, .protection_i, .tag_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cmd_start_i(cmd_start_o),
    .cmd_length_i(cmd_length_o), .cmd_protection_i(cmd_protection_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending)
  );

  // Command side: a random stall before each word, then ready until it moves.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[deferred_protection_merge_queue_core] ERROR");
        $finish;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the request word is taken.
  task automatic send_request(dpmq_pkg::op_e op, logic [SW-1:0] s, logic [LW-1:0] len,
                              logic [PW-1:0] p, logic [dpmq_pkg::TAG_W-1:0] tg);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    range_start_i  <= s;
    range_length_i <= len;
    protection_i   <= p;
    tag_i          <= tg;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    // Flushes that find nothing to issue may still be running.
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(dpmq_pkg::reg_e idx, logic [dpmq_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [SW-1:0] near_addr();
    return window + SW'($urandom_range(0, 63) * 64 + $urandom_range(0, 63));
  endfunction

  function automatic logic [SW-1:0] any_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic random_request();
    int pick;
    logic [LW-1:0] len;
    logic [PW-1:0] p;
    logic [dpmq_pkg::TAG_W-1:0] tg;
    logic [SW-1:0] s;
    pick = $urandom_range(0, 99);
    s = ($urandom_range(0, 19) == 0) ? any_addr() : near_addr();
    len = ($urandom_range(0, 14) == 0) ? {1'b0, 32'($urandom)} + 1'b1
                                       : LW'($urandom_range(1, 300));
    if ($urandom_range(0, 29) == 0) len = {1'b1, 32'b0};
    p = ($urandom_range(0, 24) == 0) ? PW'($urandom_range(5, 7))
                                     : PW'($urandom_range(0, 4));
    tag_ctr = tag_ctr + 64'($urandom_range(0, 3));
    tg = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : tag_ctr;
    if (pick < 58) send_request(dpmq_pkg::OP_PROTECT, s, len, p, tg);
    else if (pick < 68) send_request(dpmq_pkg::OP_PROTECT_NOW, s, len, p, tg);
    else if (pick < 76) send_request(dpmq_pkg::OP_FLUSH_RANGE, s, len, p, tg);
    else if (pick < 83)
      send_request(dpmq_pkg::OP_FLUSH_GUEST, near_addr() - base_addr, len, p, tg);
    else if (pick < 91)
      send_request(dpmq_pkg::OP_FLUSH_TAG, s, len, p,
                   tag_ctr - 64'($urandom_range(0, 40)));
    else if (pick < 95) send_request(dpmq_pkg::OP_FLUSH_ALL, s, len, p, tg);
    else if (pick < 97) send_request(dpmq_pkg::op_e'($urandom_range(6, 7)), s, len, p, tg);
    else send_request(dpmq_pkg::op_e'($urandom_range(0, 3)), s, '0, p, tg);
  endtask

  initial begin
    logic [dpmq_pkg::CFG_W-1:0] bases[4];
    logic [dpmq_pkg::CFG_W-1:0] bypasses[4];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    window = 48'h0000_1000_0000;
    base_addr = 48'h0000_0800_0000;
    write_reg(dpmq_pkg::REG_BYPASS, '0);
    write_reg(dpmq_pkg::REG_BASE_ADDR, base_addr);

    // Merge, cover, conflict, unlock and flush cases on a small window.
    send_request(dpmq_pkg::OP_PROTECT, window, 33'h100, dpmq_pkg::PROT_RO, 64'd1);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h100, 33'h80, dpmq_pkg::PROT_RO, 64'd2);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h400, 33'h40, dpmq_pkg::PROT_RX, 64'd3);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h3F0, 33'h100, dpmq_pkg::PROT_NO, 64'd4);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h20, 33'h10, dpmq_pkg::PROT_RW, 64'd5);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h2000, 33'h10, 3'd7, 64'd6);
    send_request(dpmq_pkg::OP_PROTECT, window + 48'h2000, 33'h100, dpmq_pkg::PROT_WX, 64'd7);
    send_request(dpmq_pkg::OP_PROTECT, 48'hFFFF_FFFF_FF00, {1'b1, 32'b0}, 3'd5, '1);
    send_request(dpmq_pkg::OP_FLUSH_TAG, '0, 33'h1, dpmq_pkg::PROT_RW, 64'd3);
    send_request(dpmq_pkg::OP_PROTECT_NOW, 48'hFFFF_FFFF_FFF0, 33'h1, dpmq_pkg::PROT_RX, '0);
    send_request(dpmq_pkg::OP_FLUSH_GUEST, 48'hFFFF_FFFF_FFFF - base_addr + 48'h1, 33'h1,
                 dpmq_pkg::PROT_RW, '0);
    send_request(dpmq_pkg::OP_FLUSH_RANGE, window, '0, dpmq_pkg::PROT_RW, '0);
    send_request(dpmq_pkg::OP_PROTECT, window, '0, dpmq_pkg::PROT_RO, '0);
    send_request(dpmq_pkg::OP_PROTECT_NOW, window, '0, dpmq_pkg::PROT_RO, '0);
    send_request(dpmq_pkg::op_e'(3'd6), window, 33'h10, dpmq_pkg::PROT_RO, '0);
    send_request(dpmq_pkg::op_e'(3'd7), window, 33'h10, dpmq_pkg::PROT_RO, '0);
    // Seventeen disjoint entries overflow the sixteen-entry queue.
    for (int i = 0; i < 17; i++)
      send_request(dpmq_pkg::OP_PROTECT, window + 48'h10000 * i, 33'h10,
                   (i % 2 == 0) ? dpmq_pkg::PROT_RO : dpmq_pkg::PROT_NO, 64'(i));
    send_request(dpmq_pkg::OP_FLUSH_RANGE, window, {1'b1, 32'b0}, dpmq_pkg::PROT_RW, '0);
    send_request(dpmq_pkg::OP_FLUSH_ALL, '0, '0, dpmq_pkg::PROT_RW, '0);
    wait_drained();

    bases[0] = '0;             bypasses[0] = '0;
    bases[1] = '1;             bypasses[1] = '0;
    bases[2] = any_addr();     bypasses[2] = 48'd1;
    bases[3] = any_addr();     bypasses[3] = '0;
    for (int ph = 0; ph < 4; ph++) begin
      base_addr = bases[ph];
      window = (ph == 1) ? 48'hFFFF_FFFF_F000 : any_addr();
      write_reg(dpmq_pkg::REG_BYPASS, bypasses[ph]);
      write_reg(dpmq_pkg::REG_BASE_ADDR, base_addr);
      for (int i = 0; i < 36; i++) begin
        if (i % 12 == 0) begin
          in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 13;
          out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
        end
        random_request();
      end
      send_request(dpmq_pkg::OP_FLUSH_ALL, '0, '0, dpmq_pkg::PROT_RW, '0);
      wait_drained();
    end

    if (errors == 0) $display("[deferred_protection_merge_queue_core] OK");
    else $display("[deferred_protection_merge_queue_core] ERROR");
    $finish;
  end

endmodule

/* files.f */
src/dpmq_pkg.sv
src/dpmq_cmp.sv
src/deferred_protection_merge_queue_core.sv
tb/sv/dpmq_checker.sv
tb/sv/testbench.sv
